// ----- src/anc_pd_pkg.sv -----
`default_nettype none

package anc_pd_pkg;

  localparam int unsigned PAYLOAD_SIZE_BITS_DEF = 20;
  localparam int unsigned PB_W                  = 20;
  localparam int unsigned HDR_BYTES             = 6;
  localparam int unsigned MAX_RES               = 4;
  localparam int unsigned UDW_BITS              = 10;
  localparam int unsigned ACC_W                 = 25;

  typedef enum logic [2:0] {
    KIND_FRAME = 3'd0,
    KIND_ELEM  = 3'd1,
    KIND_BYTE  = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_TOO_SMALL = 2'd0,
    ERR_LENGTH    = 2'd1,
    ERR_SHORT     = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FRAME = 3'd1,
    PH_SKIP  = 3'd2,
    PH_ELEM  = 3'd3,
    PH_UDW   = 3'd4,
    PH_CSUM  = 3'd5,
    PH_DONE  = 3'd6,
    PH_ERR   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [15:0]     data_word;
    logic            first_word;
    logic            last_word;
    logic [PB_W-1:0] payload_bytes;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] packet_length;
    logic [7:0]  element_count;
    logic [10:0] line_number;
    logic [7:0]  data_id;
    logic [7:0]  secondary_id;
    logic [7:0]  data_count;
    logic [7:0]  user_byte;
    logic        frame_complete;
    err_t        error_code;
    logic        last_result;
  } out_item_t;

  // results caused by one input word
  typedef struct packed {
    out_item_t [MAX_RES-1:0] item;
    logic [2:0]              count;
  } res_set_t;

endpackage

`default_nettype wire

// ----- src/anc_pd_parser.sv -----
`default_nettype none

module anc_pd_parser #(
  parameter int unsigned PAYLOAD_SIZE_BITS = anc_pd_pkg::PAYLOAD_SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire anc_pd_pkg::in_item_t word,
  output anc_pd_pkg::res_set_t      results
);
  import anc_pd_pkg::*;

  localparam int unsigned SIZE_W = (PAYLOAD_SIZE_BITS < PB_W) ? PAYLOAD_SIZE_BITS : PB_W;

  phase_t            phase, phase_next;
  logic              wc, wc_next;
  logic [1:0]        hidx, hidx_next;
  logic [8:0]        acc, acc_next;
  logic [3:0]        bcnt, bcnt_next;
  logic [7:0]        elem_left, elem_left_next;
  logic [7:0]        data_left, data_left_next;
  logic [15:0]       len, len_next;
  logic [SIZE_W-1:0] psize, psize_next;
  logic [15:0]       hw0, hw0_next;
  logic [15:0]       hw1, hw1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      wc        <= 1'b0;
      hidx      <= '0;
      acc       <= '0;
      bcnt      <= '0;
      elem_left <= '0;
      data_left <= '0;
      len       <= '0;
      psize     <= '0;
      hw0       <= '0;
      hw1       <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      wc        <= wc_next;
      hidx      <= hidx_next;
      acc       <= acc_next;
      bcnt      <= bcnt_next;
      elem_left <= elem_left_next;
      data_left <= data_left_next;
      len       <= len_next;
      psize     <= psize_next;
      hw0       <= hw0_next;
      hw1       <= hw1_next;
    end
  end

  always_comb begin
    out_item_t          r;
    logic [2:0]         n;
    logic               go;
    logic [ACC_W-1:0]   wacc;
    logic [4:0]         wbc;
    logic [UDW_BITS-1:0] v;
    logic [7:0]         cnt;

    phase_next     = phase;
    wc_next        = wc;
    hidx_next      = hidx;
    acc_next       = acc;
    bcnt_next      = bcnt;
    elem_left_next = elem_left;
    data_left_next = data_left;
    len_next       = len;
    psize_next     = psize;
    hw0_next       = hw0;
    hw1_next       = hw1;
    results        = '0;
    n              = '0;
    go             = 1'b1;
    r              = '0;
    wacc           = '0;
    wbc            = '0;
    v              = '0;
    cnt            = '0;

    if (word.first_word) begin
      wc_next        = 1'b0;
      hidx_next      = '0;
      acc_next       = '0;
      bcnt_next      = '0;
      elem_left_next = '0;
      data_left_next = '0;
      len_next       = '0;
      hw0_next       = '0;
      hw1_next       = '0;
      psize_next     = word.payload_bytes[SIZE_W-1:0];
      if (21'(psize_next) < 21'(HDR_BYTES)) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = ERR_TOO_SMALL;
        results.item[n[1:0]] = r;
        n = n + 3'd1;
        phase_next = PH_ERR;
        go = 1'b0;
      end else begin
        phase_next = PH_FRAME;
      end
    end

    if (go && phase_next != PH_IDLE && phase_next != PH_DONE && phase_next != PH_ERR) begin
      wc_next = ~wc_next;
      case (phase_next)
        PH_FRAME: begin
          if (hidx_next == 2'd0) begin
            len_next  = word.data_word;
            hidx_next = 2'd1;
          end else if (hidx_next == 2'd1) begin
            hw0_next  = word.data_word;
            hidx_next = 2'd2;
          end else if ((21'(len_next) + 21'(HDR_BYTES)) > 21'(psize_next)) begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = ERR_LENGTH;
            results.item[n[1:0]] = r;
            n = n + 3'd1;
            phase_next = PH_ERR;
          end else begin
            cnt = hw0_next[15:8];
            r = '0;
            r.kind = KIND_FRAME;
            r.packet_length = len_next;
            r.element_count = cnt;
            if (cnt == 8'd0) begin
              r.frame_complete = 1'b1;
              phase_next = PH_DONE;
            end else begin
              elem_left_next = cnt;
              hidx_next      = '0;
              phase_next     = wc_next ? PH_ELEM : PH_SKIP;
            end
            results.item[n[1:0]] = r;
            n = n + 3'd1;
          end
        end
        PH_SKIP: phase_next = PH_ELEM;
        PH_ELEM: begin
          if (hidx_next == 2'd0) begin
            hw0_next  = word.data_word;
            hidx_next = 2'd1;
          end else if (hidx_next == 2'd1) begin
            hidx_next = 2'd2;
          end else if (hidx_next == 2'd2) begin
            hw1_next  = word.data_word;
            hidx_next = 2'd3;
          end else begin
            r = '0;
            r.kind         = KIND_ELEM;
            r.line_number  = hw0_next[14:4];
            r.data_id      = hw1_next[13:6];
            r.secondary_id = {hw1_next[3:0], word.data_word[15:12]};
            r.data_count   = word.data_word[9:2];
            results.item[n[1:0]] = r;
            n = n + 3'd1;
            data_left_next = word.data_word[9:2];
            acc_next       = {7'd0, word.data_word[1:0]};
            bcnt_next      = 4'd2;
            hidx_next      = '0;
            phase_next     = (data_left_next != 8'd0) ? PH_UDW : PH_CSUM;
          end
        end
        PH_UDW, PH_CSUM: begin
          // at most two 10-bit words fit in the carry plus one new word
          wacc = {acc_next, word.data_word};
          wbc  = 5'(bcnt_next) + 5'd16;
          for (int i = 0; i < 2; i++) begin
            if (wbc >= 5'(UDW_BITS) && (phase_next == PH_UDW || phase_next == PH_CSUM)) begin
              v    = UDW_BITS'(wacc >> (wbc - 5'(UDW_BITS)));
              wbc  = wbc - 5'(UDW_BITS);
              wacc = wacc & ~({ACC_W{1'b1}} << wbc);
              r = '0;
              if (phase_next == PH_UDW) begin
                r.kind      = KIND_BYTE;
                r.user_byte = v[7:0];
                data_left_next = data_left_next - 8'd1;
                if (data_left_next == 8'd0) phase_next = PH_CSUM;
              end else begin
                // checksum word: element done, leftover bits dropped
                r.kind = KIND_END;
                wacc = '0;
                wbc  = '0;
                elem_left_next = elem_left_next - 8'd1;
                if (elem_left_next == 8'd0) begin
                  r.frame_complete = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  hidx_next  = '0;
                  phase_next = wc_next ? PH_ELEM : PH_SKIP;
                end
              end
              results.item[n[1:0]] = r;
              n = n + 3'd1;
            end
          end
          acc_next  = wacc[8:0];
          bcnt_next = wbc[3:0];
        end
        default: ;
      endcase

      if (word.last_word && phase_next != PH_DONE && phase_next != PH_ERR) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = ERR_SHORT;
        results.item[n[1:0]] = r;
        n = n + 3'd1;
        phase_next = PH_ERR;
      end
    end

    if (n != 3'd0) results.item[2'(n - 3'd1)].last_result = 1'b1;
    results.count = n;
  end

endmodule

`default_nettype wire

// ----- src/anc_payload_depacketizer_core.sv -----
// Ancillary-data payload depacketizer.
// Input channel (word_valid/word_ready/word): one big-endian 16-bit payload word per
// transaction, first_word marks word 0 and carries the payload size, last_word marks
// the last readable word. Output channel (result_valid/result_ready/result): frame
// headers, element headers, user bytes, element ends and errors, one per transaction;
// last_result flags the final result caused by a word.
// Results of a word are registered and appear the cycle after it is accepted.
// Throughput: a word causing zero or one result is taken every cycle while the receiver
// takes results; a word causing k results (at most 3) holds off the next word until the
// single result port has drained the per-word result buffer. The next word is accepted
// in the same cycle the last buffered result is taken.
// Reset: parser goes idle and waits for a word with first_word; buffered results are
// dropped. When the receiver stalls, the buffer holds and word_ready stays low
// until its last result is taken.
`default_nettype none

module anc_payload_depacketizer_core #(
  parameter int unsigned PAYLOAD_SIZE_BITS = anc_pd_pkg::PAYLOAD_SIZE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  word_valid,
  output logic                       word_ready,
  input  wire anc_pd_pkg::in_item_t  word,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output anc_pd_pkg::out_item_t      result
);
  import anc_pd_pkg::*;

  logic                    accept;
  res_set_t                res_set;
  out_item_t [MAX_RES-1:0] buf_item;
  logic [2:0]              buf_cnt;
  logic [1:0]              rd_idx;
  logic                    rd_last;

  anc_pd_parser #(
    .PAYLOAD_SIZE_BITS(PAYLOAD_SIZE_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .word    (word),
    .results (res_set)
  );

  assign result_valid = (buf_cnt != 3'd0);
  assign rd_last      = (rd_idx == 2'(buf_cnt - 3'd1));
  assign word_ready   = !result_valid || (result_ready && rd_last);
  assign accept       = word_valid && word_ready;
  assign result       = buf_item[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      rd_idx  <= '0;
    end else if (accept) begin
      buf_cnt <= res_set.count;
      rd_idx  <= '0;
    end else if (result_valid && result_ready) begin
      if (rd_last) begin
        buf_cnt <= '0;
        rd_idx  <= '0;
      end else begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) buf_item <= res_set.item;
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> word_ready)
    else $error("word_ready low with empty result buffer");

  a_hold_mid_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_result) |-> !word_ready)
    else $error("new word accepted while results of previous word pending");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result.last_result) |=> result_valid)
    else $error("result sequence ended without last_result");

  a_complete_kind: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_complete) |->
      (result.kind == KIND_FRAME || result.kind == KIND_END))
    else $error("frame_complete on wrong result kind");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import anc_pd_pkg::*;

  // Tracks the parser state word by word and queues the results each word must produce.
  class anc_parse_tracker;
    out_item_t pending_results[$];
    out_item_t word_results[$];
    int errors;

    phase_t ph;
    bit odd_words;
    logic [1:0] hdr_idx;
    logic [24:0] acc;
    logic [4:0] acc_bits;
    logic [7:0] elems_left;
    logic [7:0] bytes_left;
    logic [15:0] saved_len;
    logic [PB_W-1:0] saved_size;
    logic [15:0] hdr_w0;
    logic [15:0] hdr_w2;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_IDLE;
      odd_words = 1'b0;
      hdr_idx = '0;
      acc = '0;
      acc_bits = '0;
      elems_left = '0;
      bytes_left = '0;
      saved_len = '0;
      saved_size = '0;
      hdr_w0 = '0;
      hdr_w2 = '0;
    endfunction

    function out_item_t blank(kind_t k);
      out_item_t r;
      r = '0;
      r.kind = k;
      return r;
    endfunction

    // a single word never yields more than MAX_RES results; extras are dropped
    function void add(out_item_t r);
      if (word_results.size() < MAX_RES) word_results.insert(word_results.size(), r);
    endfunction

    function void fail_with(err_t code);
      out_item_t r;
      r = blank(KIND_ERROR);
      r.error_code = code;
      add(r);
      ph = PH_ERR;
    endfunction

    // elements are 32-bit aligned: skip one word if an even count has gone by
    function void begin_element();
      hdr_idx = '0;
      ph = odd_words ? PH_ELEM : PH_SKIP;
    endfunction

    function void frame_word(logic [15:0] w);
      out_item_t r;
      case (hdr_idx)
        2'd0: begin
          saved_len = w;
          hdr_idx = 2'd1;
        end
        2'd1: begin
          hdr_w0 = w;
          hdr_idx = 2'd2;
        end
        default: begin
          if (32'(saved_len) + HDR_BYTES > 32'(saved_size)) begin
            fail_with(ERR_LENGTH);
            return;
          end
          r = blank(KIND_FRAME);
          r.packet_length = saved_len;
          r.element_count = hdr_w0[15:8];
          if (hdr_w0[15:8] == 8'd0) begin
            r.frame_complete = 1'b1;
            ph = PH_DONE;
          end else begin
            elems_left = hdr_w0[15:8];
            begin_element();
          end
          add(r);
        end
      endcase
    endfunction

    function void element_word(logic [15:0] w);
      out_item_t r;
      case (hdr_idx)
        2'd0: begin
          hdr_w0 = w;
          hdr_idx = 2'd1;
        end
        2'd1: hdr_idx = 2'd2;
        2'd2: begin
          hdr_w2 = w;
          hdr_idx = 2'd3;
        end
        default: begin
          r = blank(KIND_ELEM);
          r.line_number = hdr_w0[14:4];
          r.data_id = hdr_w2[13:6];
          r.secondary_id = {hdr_w2[3:0], w[15:12]};
          bytes_left = w[9:2];
          r.data_count = w[9:2];
          // user data starts in the two low bits of this word
          acc = 25'(w[1:0]);
          acc_bits = 5'd2;
          hdr_idx = '0;
          ph = (bytes_left != 8'd0) ? PH_UDW : PH_CSUM;
          add(r);
        end
      endcase
    endfunction

    function void packed_word(logic [15:0] w);
      out_item_t r;
      logic [9:0] v;
      acc = {acc[8:0], w};
      acc_bits = acc_bits + 5'd16;
      while (acc_bits >= 5'd10 && (ph == PH_UDW || ph == PH_CSUM)) begin
        v = 10'(acc >> (acc_bits - 5'd10));
        acc_bits = acc_bits - 5'd10;
        acc = acc & ((25'd1 << acc_bits) - 25'd1);
        if (ph == PH_UDW) begin
          r = blank(KIND_BYTE);
          r.user_byte = v[7:0];
          add(r);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) ph = PH_CSUM;
        end else begin
          // checksum consumed, leftover bits dropped
          r = blank(KIND_END);
          acc = '0;
          acc_bits = '0;
          elems_left = elems_left - 8'd1;
          if (elems_left == 8'd0) begin
            r.frame_complete = 1'b1;
            ph = PH_DONE;
          end else begin
            begin_element();
          end
          add(r);
        end
      end
    endfunction

    function void flush();
      if (word_results.size() > 0) word_results[word_results.size()-1].last_result = 1'b1;
      foreach (word_results[i]) pending_results.insert(pending_results.size(), word_results[i]);
      word_results.delete();
    endfunction

    function void note_word(in_item_t it);
      word_results.delete();
      if (it.first_word) begin
        clear();
        saved_size = it.payload_bytes;
        if (saved_size < HDR_BYTES) begin
          fail_with(ERR_TOO_SMALL);
          flush();
          return;
        end
        ph = PH_FRAME;
      end
      if (ph == PH_IDLE || ph == PH_DONE || ph == PH_ERR) return;
      odd_words = ~odd_words;
      case (ph)
        PH_FRAME: frame_word(it.data_word);
        PH_SKIP:  ph = PH_ELEM;
        PH_ELEM:  element_word(it.data_word);
        default:  packed_word(it.data_word);
      endcase
      if (it.last_word && ph != PH_DONE && ph != PH_ERR) fail_with(ERR_SHORT);
      flush();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result transaction, kind %0d", got.kind));
        return;
      end
      want = pending_results.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("packet_length", got.packet_length, want.packet_length);
      check_field("element_count", got.element_count, want.element_count);
      check_field("line_number", got.line_number, want.line_number);
      check_field("data_id", got.data_id, want.data_id);
      check_field("secondary_id", got.secondary_id, want.secondary_id);
      check_field("data_count", got.data_count, want.data_count);
      check_field("user_byte", got.user_byte, want.user_byte);
      check_field("frame_complete", got.frame_complete, want.frame_complete);
      check_field("error_code", got.error_code, want.error_code);
      check_field("last_result", got.last_result, want.last_result);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic word_valid = 1'b0;
  logic word_ready;
  in_item_t word = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;

  anc_parse_tracker tracker;
  in_item_t frame_q[$];
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;

  anc_payload_depacketizer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word         (word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) result_ready <= ($urandom_range(99) >= rcv_stall_pct);

  // outputs and ready are stable mid-cycle; a transaction seen here completes at the next edge
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_result(result);
  end

  task automatic push_word(logic [15:0] w);
    in_item_t it;
    it.data_word = w;
    it.first_word = 1'b0;
    it.last_word = 1'b0;
    it.payload_bytes = PB_W'($urandom);
    frame_q.insert(frame_q.size(), it);
  endtask

  // Well-formed frame: header, then n_built elements with aligned headers and packed 10-bit
  // user words plus checksum. Announced count may differ from what is built.
  task automatic build_frame(int n_built, logic [7:0] announced, int dc_cap, bit ones);
    bit stream[$];
    bit b_hi, b_lo;
    logic [15:0] w;
    logic [9:0] v;
    logic [10:0] ln;
    logic [7:0] did, sdid, dc;
    int unsigned pb, pb_min, len_max;
    frame_q.delete();
    push_word(16'h0000);
    push_word({announced, 8'($urandom)});
    push_word(16'($urandom));
    for (int e = 0; e < n_built; e++) begin
      if (frame_q.size() % 2 == 0) push_word(16'($urandom));
      ln = ones ? '1 : 11'($urandom);
      did = ones ? '1 : 8'($urandom);
      sdid = ones ? '1 : 8'($urandom);
      dc = ones ? 8'd0 : 8'($urandom_range(dc_cap, 0));
      push_word({1'($urandom), ln, 4'($urandom)});
      push_word(16'($urandom));
      push_word({2'($urandom), did, 2'($urandom), sdid[7:4]});
      stream.delete();
      for (int k = 0; k <= int'(dc); k++) begin
        v = 10'($urandom);
        for (int b = 9; b >= 0; b--) stream.insert(stream.size(), v[b]);
      end
      while ((stream.size() - 2) % 16 != 0) stream.insert(stream.size(), 1'($urandom));
      b_hi = stream.pop_front();
      b_lo = stream.pop_front();
      push_word({sdid[3:0], 2'($urandom), dc, b_hi, b_lo});
      while (stream.size() > 0) begin
        for (int b = 15; b >= 0; b--) w[b] = stream.pop_front();
        push_word(w);
      end
    end
    pb_min = 2 * frame_q.size();
    if ($urandom_range(99) < 75) pb = pb_min + $urandom_range(3, 0);
    else pb = $urandom_range(20'hFFFFF, pb_min);
    len_max = (pb - 6 > 65535) ? 65535 : pb - 6;
    frame_q[0].data_word = 16'($urandom_range(len_max, 0));
    frame_q[0].first_word = 1'b1;
    frame_q[0].payload_bytes = PB_W'(pb);
    frame_q[frame_q.size()-1].last_word = 1'b1;
  endtask

  // Mostly clean frames; the rest break the length, the size or the word supply.
  task automatic random_frame(output int useful);
    int roll, n_built, cap, cut;
    logic [7:0] announced;
    logic [15:0] len;
    roll = $urandom_range(99);
    n_built = (roll < 10) ? 0 : (roll < 90) ? $urandom_range(3, 1) : $urandom_range(6, 4);
    cap = ($urandom_range(99) < 4) ? 255 : 12;
    announced = ($urandom_range(99) < 6) ? 8'($urandom) : 8'(n_built);
    build_frame(n_built, announced, cap, 1'b0);
    roll = $urandom_range(99);
    if (roll < 8) begin
      len = 16'($urandom);
      frame_q[0].data_word = len;
      frame_q[0].payload_bytes = PB_W'(len) + PB_W'($urandom_range(5, 0));
    end else if (roll < 13) begin
      frame_q[0].payload_bytes = PB_W'($urandom_range(5, 0));
    end else if (roll < 28) begin
      cut = $urandom_range(frame_q.size() - 2, 0);
      frame_q[frame_q.size()-1].last_word = 1'b0;
      frame_q[cut].last_word = 1'b1;
      if ($urandom_range(1)) while (frame_q.size() > cut + 1) void'(frame_q.pop_back());
    end else if (roll < 33) begin
      frame_q[frame_q.size()-1].last_word = 1'b0;
    end
    useful = frame_q.size();
    for (int i = frame_q.size() - 1; i >= 0; i--) if (frame_q[i].last_word) useful = i + 1;
    if (frame_q[0].payload_bytes < HDR_BYTES) useful = 1;
    if ($urandom_range(99) < 15) repeat ($urandom_range(3, 1)) push_word(16'($urandom));
  endtask

  task automatic send_word(in_item_t it);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      word_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    word_valid <= 1'b1;
    word <= it;
    do begin
      @(negedge clk);
      taken = word_ready;
      if (taken) tracker.note_word(it);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_word(frame_q[i]);
  endtask

  initial begin
    int send_pct[4];
    int rcv_pct[4];
    int sent, useful;
    send_pct = '{0, 67, 0, 35};
    rcv_pct = '{0, 0, 67, 35};
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      rcv_stall_pct = rcv_pct[p];
      if (p == 0) begin
        // payload smaller than the frame header, with and without last_word
        frame_q.delete();
        push_word(16'h0000);
        frame_q[0].first_word = 1'b1;
        frame_q[0].payload_bytes = '0;
        push_word(16'hffff);
        frame_q[1].first_word = 1'b1;
        frame_q[1].last_word = 1'b1;
        frame_q[1].payload_bytes = PB_W'(5);
        push_word(16'hffff);
        frame_q[2].payload_bytes = '1;
        send_frame();
        // max length, one byte too long for the payload
        build_frame(0, 8'd0, 0, 1'b0);
        frame_q[0].data_word = 16'hffff;
        frame_q[0].payload_bytes = PB_W'(65540);
        send_frame();
        // max length, exactly fitting
        build_frame(0, 8'd0, 0, 1'b0);
        frame_q[0].data_word = 16'hffff;
        frame_q[0].payload_bytes = PB_W'(65541);
        send_frame();
        // one element, all-ones ids, no user words, then a word after completion
        build_frame(1, 8'd1, 0, 1'b1);
        push_word(16'($urandom));
        send_frame();
        // minimum payload, runs out of words in the header
        build_frame(0, 8'd0, 0, 1'b0);
        frame_q[0].data_word = 16'h0000;
        frame_q[0].payload_bytes = PB_W'(HDR_BYTES);
        void'(frame_q.pop_back());
        frame_q[1].last_word = 1'b1;
        send_frame();
      end
      sent = 0;
      while (sent < 78) begin
        random_frame(useful);
        send_frame();
        sent += useful;
      end
    end

    word_valid <= 1'b0;
    rcv_stall_pct = 0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
